// ===== hw/rtl/asfdo_pkg.sv =====
// shared constants and codes for the drop-oldest audio sample fifo
package asfdo_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed widths of the control fields
  localparam int CFG_W    = 11;
  localparam int AMOUNT_W = 11;
  localparam int FILL_W   = 11;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE    = 2'd0,
    MODE_READ     = 2'd1,
    MODE_DISCARD  = 2'd2,
    MODE_TRUNCATE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_READ_EMPTY  = 2'd1,
    STAT_DISCARD_ERR = 2'd2,
    STAT_DROPPED     = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/audio_sample_fifo_drop_oldest_core.sv =====
// top level of the drop-oldest audio sample fifo
//
//  channel  dir  handshake                tdata / tuser
//  s_*      in   s_tvalid / s_tready      tdata: sample_in, amount; tuser: mode
//  m_*      out  m_tvalid / m_tready      tdata: sample_out, fill_count, newest_sample;
//                                         tuser: status
//  cfg_*    in   cfg_valid / cfg_ready    cfg_data: capacity
//
// one request per cycle while s_tready is high; after its request is accepted a result passes
// the result stage (state update and ram read) and then the output register
// the single ram read port reads the oldest sample only for a read request on a non-empty fifo
// rst clears pointer, count and newest sample; capacity returns to 1024; no clearing pass
// a stalled output holds the result stage, which then holds s_tready low
module audio_sample_fifo_drop_oldest_core
  import asfdo_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_TW  = ((SAMPLE_BITS + AMOUNT_W + 7) / 8) * 8,
  localparam int OUT_TW = ((2 * SAMPLE_BITS + FILL_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_TW-1:0]    s_tdata,   // sample_in, amount
  input  logic [MODE_W-1:0]   s_tuser,   // mode
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_TW-1:0]   m_tdata,   // sample_out, fill_count, newest_sample
  output logic [STATUS_W-1:0] m_tuser    // status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  // modulo-depth pointer add, operands stay below twice the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(n);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // architectural state
  logic [CFG_W-1:0]       capacity;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic [SAMPLE_BITS-1:0] newest;

  // result stage (waiting on ram data) and output register
  logic                   v1;
  status_t                st1_status;
  logic [FILL_W-1:0]      st1_fill;
  logic [SAMPLE_BITS-1:0] st1_newest;
  logic                   st1_is_read;

  logic [SAMPLE_BITS-1:0] o_sample;
  status_t                o_status;
  logic [FILL_W-1:0]      o_fill;
  logic [SAMPLE_BITS-1:0] o_newest;

  logic                   s_acc;
  logic                   adv1;
  mode_t                  mode;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [CMP_W-1:0]       amt_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       cap_eff;
  logic [CMP_W-1:0]       step;
  logic [CMP_W-1:0]       count_new;
  status_t                status_new;
  logic [SAMPLE_BITS-1:0] newest_next;
  logic [PTR_W-1:0]       rd_ptr_next;
  logic [CNT_W-1:0]       count_next;
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [PTR_W-1:0]       ram_wr_addr;
  logic [SAMPLE_BITS-1:0] ram_rd_data;

  assign cfg_ready = !rst;
  assign adv1      = !m_tvalid || m_tready;
  assign s_tready  = !rst && (!v1 || adv1);
  assign s_acc     = s_tvalid && s_tready;

  assign mode      = mode_t'(s_tuser);
  assign sample_in = s_tdata[SAMPLE_BITS-1:0];
  assign amt_ext   = CMP_W'(s_tdata[SAMPLE_BITS +: AMOUNT_W]);
  assign cnt_ext   = CMP_W'(count);
  assign cap_ext   = CMP_W'(capacity);

  // zero acts as one, anything above the depth acts as the depth
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_ext;
    end
  end

  always_comb begin
    step        = '0;
    count_new   = cnt_ext;
    status_new  = STAT_OK;
    newest_next = newest;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    case (mode)
      MODE_WRITE: begin
        ram_wr_en   = s_acc;
        newest_next = sample_in;
        if (cnt_ext >= cap_eff) begin
          // drop down to capacity minus one, then append
          step       = cnt_ext + CMP_W'(1) - cap_eff;
          count_new  = cap_eff;
          status_new = STAT_DROPPED;
        end else begin
          count_new = cnt_ext + CMP_W'(1);
        end
      end
      MODE_READ: begin
        if (cnt_ext == '0) begin
          status_new = STAT_READ_EMPTY;
        end else begin
          ram_rd_en = s_acc;
          step      = CMP_W'(1);
          count_new = cnt_ext - CMP_W'(1);
        end
      end
      MODE_DISCARD: begin
        if (amt_ext > cnt_ext) begin
          status_new = STAT_DISCARD_ERR;
        end else begin
          step      = amt_ext;
          count_new = cnt_ext - amt_ext;
        end
      end
      MODE_TRUNCATE: begin
        if (cnt_ext > amt_ext) begin
          step      = cnt_ext - amt_ext;
          count_new = amt_ext;
        end
      end
      default: begin
        step = '0;
      end
    endcase
  end

  // new sample lands just past the current newest entry
  assign ram_wr_addr = wrap_add(rd_ptr, count);
  assign rd_ptr_next = wrap_add(rd_ptr, step[CNT_W-1:0]);
  assign count_next  = count_new[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      count  <= '0;
      newest <= '0;
    end else if (s_acc) begin
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      newest <= newest_next;
    end
  end

  asfdo_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (sample_in),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      st1_status  <= status_new;
      st1_fill    <= count_new[FILL_W-1:0];
      st1_newest  <= (count_new == '0) ? '0 : newest_next;
      st1_is_read <= ram_rd_en;
    end
  end

  // output register; ram data holds while the result stage stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv1) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v1) begin
      o_sample <= st1_is_read ? ram_rd_data : '0;
      o_status <= st1_status;
      o_fill   <= st1_fill;
      o_newest <= st1_newest;
    end
  end

  assign m_tdata = OUT_TW'({o_newest, o_fill, o_sample});
  assign m_tuser = o_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DEPTH_C)
    else $error("stored count above depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(rd_ptr) < SUM_W'(DEPTH))
    else $error("read pointer out of range");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    s_acc && mode == MODE_WRITE |=> count != '0)
    else $error("count empty after a write");

  a_read_pops: assert property (@(posedge clk) disable iff (rst)
    s_acc && mode == MODE_READ && count != '0 |=> count == $past(count) - CNT_W'(1))
    else $error("read did not pop exactly one sample");

  a_empty_newest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_fill == '0 && CNT_W <= FILL_W |-> o_newest == '0)
    else $error("newest sample reported while empty");

endmodule

// ===== hw/rtl/asfdo_ram.sv =====
// generic single-clock ram, one write port, one registered read port
module asfdo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/tb_audio_sample_fifo_drop_oldest_core.sv =====
// self-checking testbench for the drop-oldest audio sample fifo core
module tb_audio_sample_fifo_drop_oldest_core
  import asfdo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] popped;
    status_t            status;
    logic [10:0]        fill;
    logic signed [15:0] newest;
  } fifo_result_t;

  class fifo_result_checker;
    logic [10:0]        capacity;
    logic signed [15:0] store [1024];
    int                 rd_ptr;
    int                 stored;
    logic signed [15:0] newest_val;
    fifo_result_t       awaited_results[$];
    int                 mismatches;
    int                 strays;
    int                 reports;

    function new();
      capacity   = CAP_RESET;
      rd_ptr     = 0;
      stored     = 0;
      newest_val = '0;
      mismatches = 0;
      strays     = 0;
      reports    = 0;
    endfunction

    function void drop_oldest(int n);
      if (n >= stored) begin
        rd_ptr = (rd_ptr + stored) % 1024;
        stored = 0;
      end else begin
        rd_ptr = (rd_ptr + n) % 1024;
        stored -= n;
      end
    endfunction

    // advance the fifo image by one accepted request and queue its result
    function void note_request(mode_t m, logic signed [15:0] smp, logic [10:0] amt);
      fifo_result_t r;
      int           eff;
      eff = (capacity == 0) ? 1 : (capacity > 1024) ? 1024 : int'(capacity);
      r.popped = '0;
      r.status = STAT_OK;
      case (m)
        MODE_WRITE: begin
          if (stored >= eff) begin
            drop_oldest(stored + 1 - eff);
            r.status = STAT_DROPPED;
          end
          store[(rd_ptr + stored) % 1024] = smp;
          stored++;
          newest_val = smp;
        end
        MODE_READ: begin
          if (stored == 0) r.status = STAT_READ_EMPTY;
          else begin
            r.popped = store[rd_ptr];
            drop_oldest(1);
          end
        end
        MODE_DISCARD: begin
          if (int'(amt) > stored) r.status = STAT_DISCARD_ERR;
          else drop_oldest(int'(amt));
        end
        default: begin
          if (stored > int'(amt)) drop_oldest(stored - int'(amt));
        end
      endcase
      r.fill   = stored[10:0];
      r.newest = (stored == 0) ? 16'sd0 : newest_val;
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [47:0] td, logic [1:0] tu);
      fifo_result_t       e;
      logic signed [15:0] got_out;
      logic signed [15:0] got_new;
      logic [10:0]        got_fill;
      got_out  = td[15:0];
      got_fill = td[26:16];
      got_new  = td[42:27];
      if (awaited_results.size() == 0) begin
        strays++;
        reports++;
        if (reports <= 10)
          $display("unexpected result: out=%0d status=%0d fill=%0d newest=%0d",
                   got_out, tu, got_fill, got_new);
        return;
      end
      e = awaited_results.pop_front();
      if (got_out !== e.popped || tu !== e.status || got_fill !== e.fill ||
          got_new !== e.newest) begin
        mismatches++;
        reports++;
        if (reports <= 10)
          $display({"mismatch: exp out=%0d status=%0d fill=%0d newest=%0d, ",
                    "got out=%0d status=%0d fill=%0d newest=%0d"},
                   e.popped, e.status, e.fill, e.newest, got_out, tu, got_fill, got_new);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;   // sample_in, amount
  logic [1:0]  s_tuser   = '0;   // mode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;          // sample_out, fill_count, newest_sample
  logic [1:0]  m_tuser;          // status

  int send_idle_pct = 10;
  int recv_idle_pct = 81;
  int hold_left     = 0;

  fifo_result_checker sb = new();

  always #5 clk = ~clk;

  audio_sample_fifo_drop_oldest_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // result side: check accepted results, then pick tready for the next cycle
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_req(mode_t m, logic signed [15:0] smp, logic [10:0] amt);
    // each idle cycle is drawn on its own
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, amt, smp};
    s_tuser  <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(m, smp, amt);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [10:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.capacity = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [10:0] cap, int n, int write_pct, bit reads_only);
    int                 r;
    mode_t              m;
    logic signed [15:0] smp;
    logic [10:0]        amt;
    wait_drain();
    write_capacity(cap);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) m = MODE_WRITE;
      else if (reads_only) m = MODE_READ;
      else begin
        r = $urandom_range(0, 99);
        if (r < 45) m = MODE_READ;
        else if (r < 75) m = MODE_DISCARD;
        else m = MODE_TRUNCATE;
      end
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       smp = 16'sh7fff;
          1:       smp = 16'sh8000;
          2:       smp = 16'sh0000;
          default: smp = 16'shffff;
        endcase
      end else begin
        smp = 16'($urandom);
      end
      // mostly amounts near the fill level, sometimes anything the field holds
      if ($urandom_range(0, 5) == 0) amt = 11'($urandom_range(0, 2047));
      else amt = 11'($urandom_range(0, sb.stored + 2));
      send_req(m, smp, amt);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty fifo corner cases
    send_req(MODE_READ, 16'sd0, 11'd0);
    send_req(MODE_DISCARD, 16'sd0, 11'd0);
    send_req(MODE_DISCARD, 16'sd0, 11'd1);
    send_req(MODE_TRUNCATE, 16'sd0, 11'd0);
    send_req(MODE_WRITE, 16'sh7fff, 11'd0);
    send_req(MODE_WRITE, 16'sh8000, 11'd2047);
    send_req(MODE_WRITE, 16'sh0000, 11'd0);
    send_req(MODE_WRITE, 16'shffff, 11'd0);
    send_req(MODE_READ, 16'sd0, 11'd0);
    send_req(MODE_DISCARD, 16'sd0, 11'd2047);
    send_req(MODE_TRUNCATE, 16'sd0, 11'd2047);
    send_req(MODE_DISCARD, 16'sd0, 11'd1);
    send_req(MODE_TRUNCATE, 16'sd0, 11'd1);
    send_req(MODE_READ, 16'sd0, 11'd0);
    send_req(MODE_READ, 16'sd0, 11'd0);

    // capacity 0 behaves as a single slot
    wait_drain();
    write_capacity(11'd0);
    send_req(MODE_WRITE, 16'sh1234, 11'd0);
    send_req(MODE_WRITE, -16'sd2, 11'd0);

    // fill to 8, then lower capacity below the fill level
    wait_drain();
    write_capacity(11'd8);
    for (int i = 0; i < 8; i++) send_req(MODE_WRITE, 16'(i * 4099 - 16000), 11'd0);
    wait_drain();
    write_capacity(11'd3);
    send_req(MODE_WRITE, 16'sh5a5a, 11'd0);
    send_req(MODE_READ, 16'sd0, 11'd0);

    run_phase(11'd3, 55, 45, 1'b0);
    wait_drain();
    write_capacity(11'd16);
    hold_left = 300;   // output stalls long enough to back up the request side
    run_phase(11'd16, 60, 55, 1'b0);
    run_phase(11'd0, 50, 45, 1'b0);
    run_phase(11'd64, 60, 60, 1'b0);

    send_idle_pct = 81;
    recv_idle_pct = 10;
    run_phase(11'd1, 50, 45, 1'b0);
    run_phase(11'd5, 55, 50, 1'b0);
    run_phase(11'd1024, 60, 60, 1'b0);
    run_phase(11'd9, 55, 45, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // capacity above the depth acts as the full depth, then tiny capacities
    run_phase(11'd2047, 30, 90, 1'b1);
    run_phase(11'd2, 25, 45, 1'b0);
    run_phase(11'd7, 25, 50, 1'b0);

    wait_drain();
    if (sb.mismatches == 0 && sb.strays == 0 && sb.awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/asfdo_pkg.sv
hw/rtl/asfdo_ram.sv
hw/rtl/audio_sample_fifo_drop_oldest_core.sv
sim/tb_audio_sample_fifo_drop_oldest_core.sv
